/* hw/rtl/rtab_pkg.sv */
// ----------------------------------------------------------------------------
// rtab_pkg
// Shared types and constants for the rank table block.
// ----------------------------------------------------------------------------
package rtab_pkg;

  localparam int FIELD_W = 16;
  localparam int INDEX_W = 4;
  localparam int INDEX_SPACE = 2 ** INDEX_W;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  // One classified request travelling from the front to the back.
  typedef struct packed {
    action_t              act;
    logic                 in_table;
    logic [INDEX_W-1:0]   idx;
    logic [FIELD_W-1:0]   total_ranks;
    logic [FIELD_W-1:0]   local_rank;
    logic [FIELD_W-1:0]   session_id;
  } cmd_t;

  // One table entry, also the shape of a lookup result.
  typedef struct packed {
    logic [FIELD_W-1:0] session;
    logic [FIELD_W-1:0] own_rank;
    logic [FIELD_W-1:0] local_rank;
    logic [FIELD_W-1:0] total_ranks;
  } entry_t;

endpackage

/* hw/rtl/rtab_fifo.sv */
// ----------------------------------------------------------------------------
// rtab_fifo
// Small synchronous FIFO, flip-flop storage, head shown while not empty.
// ----------------------------------------------------------------------------
module rtab_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/rtab_front.sv */
// ----------------------------------------------------------------------------
// rtab_front
// Classifies an incoming request into a command for the back end.
// ----------------------------------------------------------------------------
module rtab_front #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                action,
  input  logic [rtab_pkg::INDEX_W-1:0]        rank_index,
  input  logic [rtab_pkg::FIELD_W-1:0]        total_ranks,
  input  logic [rtab_pkg::FIELD_W-1:0]        local_rank,
  input  logic [rtab_pkg::FIELD_W-1:0]        session_id,
  output rtab_pkg::cmd_t                      cmd
);

  always_comb begin
    cmd.act         = rtab_pkg::action_t'(action);
    // indices at or past the depth never hit and are never written
    cmd.in_table    = (32'(rank_index) < TABLE_DEPTH);
    cmd.idx         = rank_index;
    cmd.total_ranks = total_ranks;
    cmd.local_rank  = local_rank;
    cmd.session_id  = session_id;
  end

endmodule

/* hw/rtl/rtab_back.sv */
// ----------------------------------------------------------------------------
// rtab_back
// Executes commands in order against the table: loads, range clear, lookups.
// ----------------------------------------------------------------------------
module rtab_back #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  rtab_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  input  logic            res_full,
  output logic            res_push,
  output rtab_pkg::entry_t res
);

  // only indices reachable by the index field can ever hold an entry
  localparam int STORE = (TABLE_DEPTH < rtab_pkg::INDEX_SPACE) ?
                         TABLE_DEPTH : rtab_pkg::INDEX_SPACE;
  localparam int IW    = $clog2(STORE);

  logic [STORE-1:0]              valid;
  rtab_pkg::entry_t              entry_data [STORE];
  logic [rtab_pkg::FIELD_W-1:0]  loaded_count;
  logic [rtab_pkg::FIELD_W-1:0]  loaded_count_next;
  logic [IW-1:0]                 sel;
  logic                          is_load;
  logic                          do_load;
  logic                          seq_end;
  logic                          hit;

  assign sel     = cmd.idx[IW-1:0];
  assign is_load = (cmd.act == rtab_pkg::ACT_LOAD);
  assign cmd_pop = !cmd_empty && (is_load || !res_full);
  assign do_load = cmd_pop && is_load;

  assign loaded_count_next = loaded_count + 1'b1;
  assign seq_end           = (loaded_count_next == cmd.total_ranks);

  assign hit      = cmd.in_table && valid[sel];
  assign res_push = cmd_pop && !is_load && hit;
  assign res      = entry_data[sel];

  // data of an invalid entry is never read, so only the marks are cleared
  always_ff @(posedge clk) begin
    if (do_load && cmd.in_table) begin
      entry_data[sel].total_ranks <= cmd.total_ranks;
      entry_data[sel].local_rank  <= cmd.local_rank;
      entry_data[sel].own_rank    <= rtab_pkg::FIELD_W'(cmd.idx);
      entry_data[sel].session     <= cmd.session_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid        <= '0;
      loaded_count <= '0;
    end else if (do_load) begin
      for (int i = 0; i < STORE; i++) begin
        if (cmd.in_table && (sel == IW'(i))) begin
          valid[i] <= 1'b1;
        end
        // end of sequence: everything from the count upwards goes invalid
        if (seq_end && (rtab_pkg::FIELD_W'(i) >= loaded_count_next)) begin
          valid[i] <= 1'b0;
        end
      end
      loaded_count <= seq_end ? '0 : loaded_count_next;
    end
  end

endmodule

/* hw/rtl/rank_table_load_and_lookup.sv */
// ----------------------------------------------------------------------------
// rank_table_load_and_lookup
// Rank-indexed communicator table with load sequences and lookups.
// ----------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  request  | push / full       | action, rank_index, total_ranks,
//           |                   | local_rank, session_id
//  result   | empty / pop       | out_total_ranks, out_local_rank,
//           |                   | out_own_rank, out_session
//
// One request per cycle sustained unless a lookup stalls on a full result
// queue; the back end retires a load, with any end-of-sequence range clear,
// or a lookup as it pops it. A hit passes both queues to the result ports.
// Reset (rst, synchronous) empties both queues, clears every valid mark and
// the loaded-word count; no clearing pass is needed.
// A full result queue stalls only lookups at the head of the request queue;
// the request queue then fills and raises full.
// ----------------------------------------------------------------------------
module rank_table_load_and_lookup #(
  parameter int TABLE_DEPTH = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [rtab_pkg::INDEX_W-1:0]  rank_index,
  input  logic [rtab_pkg::FIELD_W-1:0]  total_ranks,
  input  logic [rtab_pkg::FIELD_W-1:0]  local_rank,
  input  logic [rtab_pkg::FIELD_W-1:0]  session_id,
  output logic                          empty,
  input  logic                          pop,
  output logic [rtab_pkg::FIELD_W-1:0]  out_total_ranks,
  output logic [rtab_pkg::FIELD_W-1:0]  out_local_rank,
  output logic [rtab_pkg::FIELD_W-1:0]  out_own_rank,
  output logic [rtab_pkg::FIELD_W-1:0]  out_session
);

  rtab_pkg::cmd_t   in_cmd;
  rtab_pkg::cmd_t   head_cmd;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  rtab_pkg::entry_t res_in;
  rtab_pkg::entry_t res_head;

  // front: classify the request
  rtab_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .action      (action),
    .rank_index  (rank_index),
    .total_ranks (total_ranks),
    .local_rank  (local_rank),
    .session_id  (session_id),
    .cmd         (in_cmd)
  );

  // request queue: decouples the port from the table
  rtab_fifo #(
    .WIDTH ($bits(rtab_pkg::cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (head_cmd),
    .empty (cmd_empty)
  );

  // back: table update and lookup, strictly in request order
  rtab_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (head_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // result queue: output register stage, lets the consumer stall freely
  rtab_fifo #(
    .WIDTH ($bits(rtab_pkg::entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_total_ranks = res_head.total_ranks;
  assign out_local_rank  = res_head.local_rank;
  assign out_own_rank    = res_head.own_rank;
  assign out_session     = res_head.session;

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rank table: a directed table of requests, then
// random load sequences and lookups, then a look at every entry. Every
// accepted request is fed to an in-bench copy of the table; lookup hits are
// queued and matched in order against what the block hands out.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  // One request as the sender offers it.
  typedef struct {
    rtab_pkg::action_t                act;
    logic [rtab_pkg::INDEX_W-1:0]     idx;
    logic [rtab_pkg::FIELD_W-1:0]     total;
    logic [rtab_pkg::FIELD_W-1:0]     loc;
    logic [rtab_pkg::FIELD_W-1:0]     sess;
  } req_t;

  // One row of the directed table. Rows marked fixed carry their own answer;
  // the rest are checked against the table copy.
  typedef struct {
    req_t             rq;
    bit               fixed;
    bit               hit;
    rtab_pkg::entry_t want;
  } row_t;

  logic                         clk;
  logic                         rst;
  logic                         push;
  logic                         full;
  logic                         action;
  logic [rtab_pkg::INDEX_W-1:0] rank_index;
  logic [rtab_pkg::FIELD_W-1:0] total_ranks;
  logic [rtab_pkg::FIELD_W-1:0] local_rank;
  logic [rtab_pkg::FIELD_W-1:0] session_id;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [rtab_pkg::FIELD_W-1:0] out_total_ranks;
  logic [rtab_pkg::FIELD_W-1:0] out_local_rank;
  logic [rtab_pkg::FIELD_W-1:0] out_own_rank;
  logic [rtab_pkg::FIELD_W-1:0] out_session;

  rank_table_load_and_lookup #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .action         (action),
    .rank_index     (rank_index),
    .total_ranks    (total_ranks),
    .local_rank     (local_rank),
    .session_id     (session_id),
    .empty          (empty),
    .pop            (pop),
    .out_total_ranks(out_total_ranks),
    .out_local_rank (out_local_rank),
    .out_own_rank   (out_own_rank),
    .out_session    (out_session)
  );

  // --------------------------------------------------------------------------
  // Table copy: valid marks, entries and the loaded-word count
  // --------------------------------------------------------------------------
  logic               tbl_valid [DEPTH];
  rtab_pkg::entry_t   tbl_entry [DEPTH];
  logic [15:0]        word_count;

  rtab_pkg::entry_t   pending_hits[$];   // lookup hits still owed by the block
  row_t               directed_rows[$];
  int                 accepted;          // requests taken by the block so far
  int                 hits_checked = 0;
  int                 errors = 0;
  int                 burst_left;

  // Applies one request to the table copy; a lookup of a valid entry hits.
  function automatic void table_apply(input req_t rq, output bit hit,
                                      output rtab_pkg::entry_t found);
    rtab_pkg::entry_t e;
    hit   = 1'b0;
    found = '0;
    if (rq.act == rtab_pkg::ACT_LOAD) begin
      if (int'(rq.idx) < DEPTH) begin
        e.total_ranks = rq.total;
        e.local_rank  = rq.loc;
        e.own_rank    = {{(rtab_pkg::FIELD_W-rtab_pkg::INDEX_W){1'b0}}, rq.idx};
        e.session     = rq.sess;
        tbl_valid[rq.idx] = 1'b1;
        tbl_entry[rq.idx] = e;
      end
      word_count = word_count + 16'd1;
      // Sequence ends: sweep everything from the count upwards.
      if (word_count == rq.total) begin
        for (int i = int'(word_count); i < DEPTH; i++) begin
          tbl_valid[i] = 1'b0;
          tbl_entry[i] = '0;
        end
        word_count = '0;
      end
    end else if (int'(rq.idx) < DEPTH && tbl_valid[rq.idx]) begin
      hit   = 1'b1;
      found = tbl_entry[rq.idx];
    end
  endfunction

  task automatic flag(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of back-to-back requests with random gaps between them.
  // Each request is applied to the table copy at the edge that accepts it.
  // --------------------------------------------------------------------------
  task automatic issue(input req_t rq, input bit fixed, input bit f_hit,
                       input rtab_pkg::entry_t f_want);
    bit               hit;
    rtab_pkg::entry_t found;
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long gapless stretch
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    push        <= 1'b1;
    action      <= rq.act;
    rank_index  <= rq.idx;
    total_ranks <= rq.total;
    local_rank  <= rq.loc;
    session_id  <= rq.sess;
    @(posedge clk);
    while (full) @(posedge clk);
    burst_left--;
    accepted++;
    table_apply(rq, hit, found);
    if (fixed) begin
      hit   = f_hit;
      found = f_want;
    end
    if (hit) pending_hits.push_back(found);
  endtask

  task automatic send_load(input logic [rtab_pkg::INDEX_W-1:0] idx,
                           input logic [rtab_pkg::FIELD_W-1:0] total);
    req_t rq;
    rq.act   = rtab_pkg::ACT_LOAD;
    rq.idx   = idx;
    rq.total = total;
    rq.loc   = 16'($urandom);
    rq.sess  = 16'($urandom);
    issue(rq, 1'b0, 1'b0, '0);
  endtask

  // load-only fields are left random on a lookup; the block must ignore them
  task automatic send_lookup(input logic [rtab_pkg::INDEX_W-1:0] idx);
    req_t rq;
    rq.act   = rtab_pkg::ACT_LOOKUP;
    rq.idx   = idx;
    rq.total = 16'($urandom);
    rq.loc   = 16'($urandom);
    rq.sess  = 16'($urandom);
    issue(rq, 1'b0, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  task automatic row_load(input logic [3:0] idx, input logic [15:0] tot, input logic [15:0] loc,
                          input logic [15:0] ses);
    row_t r;
    r.rq.act = rtab_pkg::ACT_LOAD;
    r.rq.idx = idx;
    r.rq.total = tot;
    r.rq.loc = loc;
    r.rq.sess = ses;
    r.fixed = 1'b0;
    r.hit = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endtask

  task automatic row_lookup(input logic [3:0] idx);
    row_t r;
    r.rq.act = rtab_pkg::ACT_LOOKUP;
    r.rq.idx = idx;
    r.rq.total = '0;
    r.rq.loc = '0;
    r.rq.sess = '0;
    r.fixed = 1'b0;
    r.hit = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endtask

  // lookup whose outcome is plain to see: a hit with these fields
  task automatic row_seen(input logic [3:0] idx, input logic [15:0] tot, input logic [15:0] loc,
                          input logic [15:0] own, input logic [15:0] ses);
    row_t r;
    r.rq.act = rtab_pkg::ACT_LOOKUP;
    r.rq.idx = idx;
    r.rq.total = '1;
    r.rq.loc = '1;
    r.rq.sess = '1;
    r.fixed = 1'b1;
    r.hit = 1'b1;
    r.want.total_ranks = tot;
    r.want.local_rank = loc;
    r.want.own_rank = own;
    r.want.session = ses;
    directed_rows.push_back(r);
  endtask

  // lookup that must give nothing back
  task automatic row_absent(input logic [3:0] idx);
    row_t r;
    r.rq.act = rtab_pkg::ACT_LOOKUP;
    r.rq.idx = idx;
    r.rq.total = '0;
    r.rq.loc = '0;
    r.rq.sess = '0;
    r.fixed = 1'b1;
    r.hit = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: pops on a rotating 8-bit stall pattern, reshuffled periodically,
  // sometimes all ones. Once, early in the random part, it holds off for a
  // long stretch so that both queues fill and full rises.
  // --------------------------------------------------------------------------
  logic [7:0]       stall_pat = 8'hFF;
  int               pat_age = 0;
  int               holdoff_left = 0;
  bit               held_once = 1'b0;
  rtab_pkg::entry_t owed;

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_hits.size() == 0) begin
        flag($sformatf("result with no lookup hit owed (total %h local %h own %h session %h)",
                       out_total_ranks, out_local_rank, out_own_rank, out_session));
      end else begin
        owed = pending_hits.pop_front();
        if (out_total_ranks !== owed.total_ranks)
          flag($sformatf("out_total_ranks %h, want %h", out_total_ranks, owed.total_ranks));
        if (out_local_rank !== owed.local_rank)
          flag($sformatf("out_local_rank %h, want %h", out_local_rank, owed.local_rank));
        if (out_own_rank !== owed.own_rank)
          flag($sformatf("out_own_rank %h, want %h", out_own_rank, owed.own_rank));
        if (out_session !== owed.session)
          flag($sformatf("out_session %h, want %h", out_session, owed.session));
      end
      hits_checked++;
    end
    pat_age++;
    if (pat_age == 64) begin
      pat_age   = 0;
      stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end else begin
      stall_pat = {stall_pat[6:0], stall_pat[7]};
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      pop <= 1'b0;
    end else if (!held_once && hits_checked >= 30) begin
      held_once    = 1'b1;
      holdoff_left = 300;
      pop <= 1'b0;
    end else begin
      pop <= stall_pat[0];
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int          pick;
    int          n;
    logic [15:0] target;
    row_t        r;

    push         = 1'b0;
    action       = 1'b0;
    rank_index   = '0;
    total_ranks  = '0;
    local_rank   = '0;
    session_id   = '0;
    accepted     = 0;
    burst_left   = 0;
    word_count   = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_entry[i] = '0;
    end

    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table. Nothing is valid after reset; a three-word sequence
    // is looked at half way, then its end sweeps entries 3 and up; a
    // one-word sequence clears its own entry; extremes of every field.
    row_absent(4'd0);
    row_absent(4'd15);
    row_load(4'd15, 16'd3, 16'hFFFF, 16'hFFFF);
    row_load(4'd0, 16'd3, 16'h0000, 16'h0000);
    row_seen(4'd15, 16'd3, 16'hFFFF, 16'd15, 16'hFFFF);   // served mid-sequence
    row_seen(4'd0, 16'd3, 16'h0000, 16'd0, 16'h0000);
    row_load(4'd7, 16'd3, 16'h1234, 16'hABCD);            // count hits 3: sweep
    row_absent(4'd7);
    row_absent(4'd15);
    row_seen(4'd0, 16'd3, 16'h0000, 16'd0, 16'h0000);     // below the sweep
    row_load(4'd1, 16'd1, 16'h5A5A, 16'hA5A5);            // ends at once
    row_absent(4'd1);
    row_seen(4'd0, 16'd3, 16'h0000, 16'd0, 16'h0000);
    row_load(4'd0, 16'hFFFF, 16'hAAAA, 16'h5555);
    row_seen(4'd0, 16'hFFFF, 16'hAAAA, 16'd0, 16'h5555);
    row_load(4'd5, 16'd0, 16'h0001, 16'h0002);
    row_lookup(4'd5);
    row_load(4'd2, 16'd3, 16'h7FFF, 16'h8000);
    row_absent(4'd5);
    row_lookup(4'd2);
    row_seen(4'd0, 16'hFFFF, 16'hAAAA, 16'd0, 16'h5555);
    row_lookup(4'd1);
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      issue(r.rq, r.fixed, r.hit, r.want);
    end

    // Random part: mostly whole load sequences with lookups mixed in,
    // some cut short, plus stray loads and runs of lookups. Sequences of
    // 16 and more words end with nothing to clear.
    while (accepted < 1130) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 15);
        target = word_count + n[15:0];
        for (int k = 0; k < n; k++) begin
          send_load(4'($urandom), target);
          if ($urandom_range(0, 2) == 0) send_lookup(4'($urandom));
        end
        repeat ($urandom_range(1, 4)) send_lookup(4'($urandom));
      end else if (pick == 7) begin
        n = $urandom_range(2, 15);
        target = word_count + n[15:0];
        repeat ($urandom_range(1, n - 1)) send_load(4'($urandom), target);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 3))
          send_load(4'($urandom),
                    $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 20)));
      end else begin
        repeat ($urandom_range(1, 6)) send_lookup(4'($urandom));
      end
    end

    // a look at every entry
    for (int j = 0; j < DEPTH; j++) send_lookup(j[3:0]);

    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    // leave room for strays
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
